// ===== design/elsched_pkg.sv =====
// Package for the LOOK elevator scheduler: shared types, opcodes and field widths.
// No dependencies; used by elsched_step and elevator_look_scheduler.
package elsched_pkg;

  localparam int unsigned FloorW      = 4;   // width of a floor number
  localparam int unsigned NumFloorsW  = 5;   // width of the floor count register
  localparam int unsigned FieldFloors = 16;  // floors a 4-bit floor field can name
  localparam int unsigned AddrW       = 3;   // APB byte address width
  localparam int unsigned DataW       = 32;  // APB data width

  // Input opcodes, carried in tuser.
  localparam logic OpRequest = 1'b0;
  localparam logic OpTick    = 1'b1;

  // Register word indexes.
  localparam logic RegNumFloors = 1'b0;

  typedef struct packed {
    logic [FloorW-1:0] car;
    logic              up;
    logic [FloorW-1:0] upper;
    logic              upper_v;
    logic [FloorW-1:0] lower;
    logic              lower_v;
  } car_state_t;

  // Packed with served in bit 0, matching the output tdata layout.
  typedef struct packed {
    logic              bad_floor;
    logic              moving_up;
    logic [FloorW-1:0] car_floor;
    logic [FloorW-1:0] served_floor;
    logic              served;
  } result_t;

endpackage

// ===== design/elevator_look_scheduler.sv =====
// Top level of the LOOK elevator scheduler: stream ports, APB register, state and result register.
// Depends on elsched_pkg and elsched_step.
//
//  Channel   Direction  Signals                                Carries
//  --------  ---------  -------------------------------------  ---------------------------------
//  s_axis    in         s_axis_tvalid/tready/tdata/tuser       one request or tick per transaction
//  m_axis    out        m_axis_tvalid/tready/tdata             one result per input transaction
//  apb       in/out     psel/penable/pwrite/paddr/pwdata/...   num_floors register at address 0
//
// Each input transaction updates the car state and call bits in the cycle it is
// accepted; its result appears on m_axis in the next cycle, one item per cycle
// while m_axis does not stall. The single output register sets the rate: a new transaction is
// taken whenever that register is empty or being drained in the same cycle.
// Reset clears all call bits, parks the car at floor 0 heading up, drops both
// targets and sets num_floors to its largest legal value. A stall on m_axis
// holds the result and back-pressures s_axis; nothing is lost or reordered.
module elevator_look_scheduler #(
  parameter int unsigned MAX_FLOORS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [7:0]                           s_axis_tdata_i,  // [3:0] floor
  input  logic                                 s_axis_tuser_i,  // [0] opcode
  // Output stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [0] served, [4:1] served_floor, [8:5] car_floor, [9] moving_up, [10] bad_floor
  output logic [15:0]                          m_axis_tdata_o,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [elsched_pkg::AddrW-1:0]        paddr,
  input  logic [elsched_pkg::DataW-1:0]        pwdata,
  output logic [elsched_pkg::DataW-1:0]        prdata,
  output logic                                 pready
);

  // Only floors a 4-bit field can name ever get call bits.
  localparam int unsigned NumCalls = (MAX_FLOORS < elsched_pkg::FieldFloors) ?
                                     MAX_FLOORS : elsched_pkg::FieldFloors;
  localparam logic [elsched_pkg::NumFloorsW-1:0] FloorLim =
      elsched_pkg::NumFloorsW'(NumCalls);
  localparam logic [elsched_pkg::NumFloorsW-1:0] FloorMin =
      elsched_pkg::NumFloorsW'(2);
  localparam elsched_pkg::car_state_t StateReset = '{
    car: '0, up: 1'b1, upper: '0, upper_v: 1'b0, lower: '0, lower_v: 1'b0
  };

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [elsched_pkg::NumFloorsW-1:0] num_floors_q, num_floors_d;
  logic [elsched_pkg::NumFloorsW-1:0] wr_val;
  logic                               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == elsched_pkg::RegNumFloors);
  assign wr_val = pwdata[elsched_pkg::NumFloorsW-1:0];

  // Saturate the written count into the legal range.
  always_comb begin
    num_floors_d = num_floors_q;
    if (cfg_wr) begin
      if (wr_val < FloorMin) begin
        num_floors_d = FloorMin;
      end else if (wr_val > FloorLim) begin
        num_floors_d = FloorLim;
      end else begin
        num_floors_d = wr_val;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == elsched_pkg::RegNumFloors) begin
      prdata = {{(elsched_pkg::DataW - elsched_pkg::NumFloorsW){1'b0}}, num_floors_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Car state and call bits
  // ---------------------------------------------------------------------------
  elsched_pkg::car_state_t state_q, state_d;
  logic [NumCalls-1:0]     calls_q, calls_d;
  elsched_pkg::result_t    result_d;
  logic                    in_fire;

  elsched_step #(
    .NumCalls(NumCalls)
  ) u_step (
    .opcode_i    (s_axis_tuser_i),
    .floor_i     (s_axis_tdata_i[elsched_pkg::FloorW-1:0]),
    .num_floors_i(num_floors_q),
    .state_i     (state_q),
    .calls_i     (calls_q),
    .state_o     (state_d),
    .calls_o     (calls_d),
    .result_o    (result_d)
  );

  // ---------------------------------------------------------------------------
  // Output register: accept when empty or draining this cycle
  // ---------------------------------------------------------------------------
  logic                 out_valid_q;
  elsched_pkg::result_t out_data_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16 - $bits(elsched_pkg::result_t)){1'b0}}, out_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_floors_q <= FloorLim;
      state_q      <= StateReset;
      calls_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      num_floors_q <= num_floors_d;
      if (in_fire) begin
        state_q     <= state_d;
        calls_q     <= calls_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted transaction, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= result_d;
    end
  end

endmodule

// ===== design/elsched_step.sv =====
// Next-state logic for one request or tick of the LOOK elevator scheduler.
// Depends on elsched_pkg (car_state_t, result_t, opcodes).
module elsched_step #(
  parameter int unsigned NumCalls = 16
) (
  input  logic                                opcode_i,
  input  logic [elsched_pkg::FloorW-1:0]      floor_i,
  input  logic [elsched_pkg::NumFloorsW-1:0]  num_floors_i,
  input  elsched_pkg::car_state_t             state_i,
  input  logic [NumCalls-1:0]                 calls_i,
  output elsched_pkg::car_state_t             state_o,
  output logic [NumCalls-1:0]                 calls_o,
  output elsched_pkg::result_t                result_o
);

  localparam int unsigned IdxW = $clog2(NumCalls);
  localparam logic [elsched_pkg::NumFloorsW-1:0] CallLim =
      elsched_pkg::NumFloorsW'(NumCalls);

  logic [elsched_pkg::NumFloorsW-1:0] floor_ext;
  logic [elsched_pkg::NumFloorsW-1:0] car_ext;
  logic [elsched_pkg::NumFloorsW-1:0] top;
  logic                               in_range;
  logic                               car_has_slot;

  assign floor_ext    = {1'b0, floor_i};
  assign car_ext      = {1'b0, state_i.car};
  assign top          = num_floors_i - elsched_pkg::NumFloorsW'(1);
  assign in_range     = (floor_ext < num_floors_i) && (floor_ext < CallLim);
  assign car_has_slot = car_ext < CallLim;

  always_comb begin
    state_o  = state_i;
    calls_o  = calls_i;
    result_o = '0;

    if (opcode_i == elsched_pkg::OpRequest) begin
      if (!in_range) begin
        result_o.bad_floor = 1'b1;
      end else begin
        calls_o[floor_i[IdxW-1:0]] = 1'b1;
        // Widen the sweep only past the current targets.
        if (floor_i > state_i.car && (!state_i.upper_v || floor_i > state_i.upper)) begin
          state_o.upper   = floor_i;
          state_o.upper_v = 1'b1;
        end else if (floor_i < state_i.car &&
                     (!state_i.lower_v || floor_i < state_i.lower)) begin
          state_o.lower   = floor_i;
          state_o.lower_v = 1'b1;
        end
      end
    end else if (state_i.upper_v || state_i.lower_v) begin
      if (car_has_slot && calls_i[state_i.car[IdxW-1:0]]) begin
        calls_o[state_i.car[IdxW-1:0]] = 1'b0;
        result_o.served       = 1'b1;
        result_o.served_floor = state_i.car;
      end
      // Reverse at the upper end first, else at the lower end.
      if ((state_i.upper_v && state_i.upper == state_i.car) || car_ext >= top) begin
        state_o.up      = 1'b0;
        state_o.upper_v = 1'b0;
      end else if ((state_i.lower_v && state_i.lower == state_i.car) ||
                   state_i.car == '0) begin
        state_o.up      = 1'b1;
        state_o.lower_v = 1'b0;
      end
      if (state_o.up) begin
        state_o.car = state_i.car + elsched_pkg::FloorW'(1);
      end else begin
        state_o.car = state_i.car - elsched_pkg::FloorW'(1);
      end
    end

    result_o.car_floor = state_o.car;
    result_o.moving_up = state_o.up;
  end

endmodule
